FILE: src/rotating_rainbow_led_strip_assert.svh
// Assertion macros shared by the rainbow strip RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ROTATING_RAINBOW_LED_STRIP_ASSERT_SVH
`define ROTATING_RAINBOW_LED_STRIP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RRLS_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rainbow strip check failed");

// Same-cycle implication.
`define RRLS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rainbow strip check failed");

// Next-cycle implication.
`define RRLS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rainbow strip check failed");

`endif

FILE: src/rrls_pkg.sv
// Shared constants, codes and types of the rotating rainbow LED strip.
// Used by rrls_ramp, rrls_color and the top level; depends on nothing.
package rrls_pkg;

	localparam int STRIP_LENGTH     = 60;
	localparam int RESET_BRIGHTNESS = 16;
	localparam int RAMP_LEN         = STRIP_LENGTH / 6;

	localparam int POS_W   = $clog2(STRIP_LENGTH);
	localparam int PHASE_W = (RAMP_LEN > 1) ? $clog2(RAMP_LEN) : 1;
	// The running segment index can climb past six when the length is not a multiple of six.
	localparam int SEG_W   = $clog2(2 * STRIP_LENGTH / RAMP_LEN + 2);
	localparam int ACC_W   = $clog2(RAMP_LEN + 256);

	localparam int LAST_SEG   = (STRIP_LENGTH - 1) / RAMP_LEN;
	localparam int LAST_PHASE = (STRIP_LENGTH - 1) % RAMP_LEN;

	localparam logic [7:0] CMD_BRIGHTNESS = 8'h62;

	// Segment codes around the wheel; anything at or above the last one colors as magenta.
	localparam logic [SEG_W-1:0] SEG_R2Y = SEG_W'(0);
	localparam logic [SEG_W-1:0] SEG_Y2G = SEG_W'(1);
	localparam logic [SEG_W-1:0] SEG_G2C = SEG_W'(2);
	localparam logic [SEG_W-1:0] SEG_C2B = SEG_W'(3);
	localparam logic [SEG_W-1:0] SEG_B2M = SEG_W'(4);
	localparam logic [SEG_W-1:0] SEG_M2R = SEG_W'(5);

	typedef enum logic [2:0] {
		ST_FILL = 3'b001,
		ST_IDLE = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		PM_IDLE   = 3'b001,
		PM_WAIT   = 3'b010,
		PM_BROKEN = 3'b100
	} parser_mode_t;

	typedef struct packed {
		logic       start;
		logic [7:0] level;
	} fill_req_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

endpackage

FILE: src/rotating_rainbow_led_strip.sv
// Rotating rainbow LED strip: command parser, wheel position and pixel sequencer.
// A frame tick is taken and then streams STRIP_LENGTH pixels, one per cycle
// when the sink keeps tready high.
// A brightness command refills the ramp table through one shared add/subtract unit.
// After reset the same refill runs for the reset brightness before the first transfer.
module rotating_rainbow_led_strip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] command_byte, [8] direction, [15:9] zero
	input  logic        s_axis_tuser,  // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
	output logic        m_axis_tlast
);

	localparam logic [rrls_pkg::POS_W-1:0] POS_LAST =
		rrls_pkg::POS_W'(rrls_pkg::STRIP_LENGTH - 1);
	localparam logic [rrls_pkg::PHASE_W-1:0] PHASE_LAST =
		rrls_pkg::PHASE_W'(rrls_pkg::RAMP_LEN - 1);

	rrls_pkg::state_t                 state_q;
	rrls_pkg::parser_mode_t           mode_q;
	logic [rrls_pkg::POS_W-1:0]       pos_q;
	logic [rrls_pkg::SEG_W-1:0]       seg_q;
	logic [rrls_pkg::PHASE_W-1:0]     phase_q;
	logic [rrls_pkg::SEG_W-1:0]       cur_seg_q;
	logic [rrls_pkg::PHASE_W-1:0]     cur_phase_q;
	logic [rrls_pkg::POS_W-1:0]       pix_q;
	logic                             m_valid_q;
	rrls_pkg::rgb_t                   m_data_q;
	logic                             m_last_q;

	logic                             s_fire;
	logic                             slot_free;
	logic                             advance;
	logic [7:0]                       cmd_byte;
	logic                             dir;
	logic [rrls_pkg::POS_W-1:0]       pos_d;
	logic [rrls_pkg::SEG_W-1:0]       seg_d;
	logic [rrls_pkg::PHASE_W-1:0]     phase_d;
	rrls_pkg::fill_req_t              fill_req;
	logic [7:0]                       ramp_up;
	logic [7:0]                       level;
	logic                             ramp_busy;
	rrls_pkg::rgb_t                   pixel;

	assign cmd_byte      = s_axis_tdata[7:0];
	assign dir           = s_axis_tdata[8];
	assign s_axis_tready = (state_q == rrls_pkg::ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !m_valid_q || m_axis_tready;
	assign advance       = (state_q == rrls_pkg::ST_EMIT) && slot_free;

	assign fill_req.start = s_fire && !s_axis_tuser && (mode_q == rrls_pkg::PM_WAIT);
	assign fill_req.level = cmd_byte;

	// Wheel step; segment and phase track the position so no division is needed.
	always_comb begin
		if (dir) begin
			if (pos_q == POS_LAST) begin
				pos_d   = '0;
				seg_d   = '0;
				phase_d = '0;
			end else if (phase_q == PHASE_LAST) begin
				pos_d   = pos_q + 1'b1;
				seg_d   = seg_q + 1'b1;
				phase_d = '0;
			end else begin
				pos_d   = pos_q + 1'b1;
				seg_d   = seg_q;
				phase_d = phase_q + 1'b1;
			end
		end else begin
			if (pos_q == '0) begin
				pos_d   = POS_LAST;
				seg_d   = rrls_pkg::SEG_W'(rrls_pkg::LAST_SEG);
				phase_d = rrls_pkg::PHASE_W'(rrls_pkg::LAST_PHASE);
			end else if (phase_q == '0) begin
				pos_d   = pos_q - 1'b1;
				seg_d   = seg_q - 1'b1;
				phase_d = PHASE_LAST;
			end else begin
				pos_d   = pos_q - 1'b1;
				seg_d   = seg_q;
				phase_d = phase_q - 1'b1;
			end
		end
	end

	rrls_ramp u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fill_req),
		.rd_idx  (cur_phase_q),
		.rd_data (ramp_up),
		.level   (level),
		.busy    (ramp_busy)
	);

	rrls_color u_color (
		.seg   (cur_seg_q),
		.up    (ramp_up),
		.top   (level),
		.pixel (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrls_pkg::ST_FILL;
			mode_q      <= rrls_pkg::PM_IDLE;
			pos_q       <= '0;
			seg_q       <= '0;
			phase_q     <= '0;
			cur_seg_q   <= '0;
			cur_phase_q <= '0;
			pix_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				rrls_pkg::ST_FILL: begin
					if (!ramp_busy) begin
						state_q <= rrls_pkg::ST_IDLE;
					end
				end
				rrls_pkg::ST_IDLE: begin
					if (s_fire && s_axis_tuser) begin
						pos_q       <= pos_d;
						seg_q       <= seg_d;
						phase_q     <= phase_d;
						cur_seg_q   <= seg_d;
						cur_phase_q <= phase_d;
						pix_q       <= '0;
						state_q     <= rrls_pkg::ST_EMIT;
					end else if (s_fire) begin
						case (mode_q)
							rrls_pkg::PM_IDLE: begin
								mode_q <= (cmd_byte == rrls_pkg::CMD_BRIGHTNESS) ?
									rrls_pkg::PM_WAIT : rrls_pkg::PM_BROKEN;
							end
							rrls_pkg::PM_WAIT: begin
								mode_q  <= rrls_pkg::PM_IDLE;
								state_q <= rrls_pkg::ST_FILL;
							end
							default: begin
								mode_q <= rrls_pkg::PM_BROKEN;
							end
						endcase
					end
				end
				rrls_pkg::ST_EMIT: begin
					if (advance) begin
						pix_q <= pix_q + 1'b1;
						if (pix_q == POS_LAST) begin
							state_q <= rrls_pkg::ST_IDLE;
						end
						if (cur_phase_q == PHASE_LAST) begin
							cur_phase_q <= '0;
							cur_seg_q   <= (cur_seg_q == rrls_pkg::SEG_M2R) ?
								'0 : cur_seg_q + 1'b1;
						end else begin
							cur_phase_q <= cur_phase_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= rrls_pkg::ST_IDLE;
				end
			endcase

			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output register; it holds its pixel until the sink takes the transfer.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= pixel;
			m_last_q <= (pix_q == POS_LAST);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`include "rotating_rainbow_led_strip_assert.svh"

	`RRLS_ASSERT_IMP(a_emit_table_ready, state_q != rrls_pkg::ST_FILL, !ramp_busy)
	`RRLS_ASSERT(a_pos_range, pos_q <= POS_LAST)
	`RRLS_ASSERT(a_pos_split, int'(pos_q) == int'(seg_q) * rrls_pkg::RAMP_LEN + int'(phase_q))
	`RRLS_ASSERT_NXT(a_tick_starts, s_fire && s_axis_tuser, state_q == rrls_pkg::ST_EMIT && pix_q == '0)

endmodule

FILE: src/rrls_ramp.sv
// Brightness register and ramp table, refilled by one shared add/subtract unit.
// Entry i = round(level * i / RAMP_LEN), built by repeated subtraction. Uses rrls_pkg.
module rrls_ramp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrls_pkg::fill_req_t             req,
	input  logic [rrls_pkg::PHASE_W-1:0]    rd_idx,
	output logic [7:0]                      rd_data,
	output logic [7:0]                      level,
	output logic                            busy
);

	localparam logic [rrls_pkg::ACC_W-1:0] HALF =
		rrls_pkg::ACC_W'(rrls_pkg::RAMP_LEN / 2);
	localparam logic [rrls_pkg::ACC_W-1:0] NEG_LEN =
		rrls_pkg::ACC_W'(2 ** rrls_pkg::ACC_W - rrls_pkg::RAMP_LEN);
	localparam logic [rrls_pkg::ACC_W-1:0] LEN =
		rrls_pkg::ACC_W'(rrls_pkg::RAMP_LEN);
	localparam logic [rrls_pkg::PHASE_W-1:0] LAST_IDX =
		rrls_pkg::PHASE_W'(rrls_pkg::RAMP_LEN - 1);

	logic                           busy_q;
	logic [7:0]                     level_q;
	logic [rrls_pkg::ACC_W-1:0]     acc_q;
	logic [7:0]                     quo_q;
	logic [rrls_pkg::PHASE_W-1:0]   idx_q;
	logic [7:0]                     ramp_q [rrls_pkg::RAMP_LEN];

	logic                           ge;
	logic [rrls_pkg::ACC_W-1:0]     addend;
	logic [rrls_pkg::ACC_W-1:0]     sum;

	// While the remainder is at least RAMP_LEN the unit subtracts; otherwise it adds the level.
	assign ge     = (acc_q >= LEN);
	assign addend = ge ? NEG_LEN : rrls_pkg::ACC_W'(level_q);
	assign sum    = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			level_q <= 8'(rrls_pkg::RESET_BRIGHTNESS);
			acc_q   <= HALF;
			quo_q   <= 8'd0;
			idx_q   <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			level_q <= req.level;
			acc_q   <= HALF;
			quo_q   <= 8'd0;
			idx_q   <= '0;
		end else if (busy_q) begin
			acc_q <= sum;
			if (ge) begin
				quo_q <= quo_q + 8'd1;
			end else if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !ge && !req.start) begin
			ramp_q[idx_q] <= quo_q;
		end
	end

	assign rd_data = ramp_q[rd_idx];
	assign level   = level_q;
	assign busy    = busy_q;

endmodule

FILE: src/rrls_color.sv
// Maps a wheel segment and ramp value to one RGB pixel.
// Purely combinational; uses codes and types from rrls_pkg.
module rrls_color (
	input  logic [rrls_pkg::SEG_W-1:0] seg,
	input  logic [7:0]                 up,
	input  logic [7:0]                 top,
	output rrls_pkg::rgb_t             pixel
);

	logic [7:0] down;

	assign down = top - up;

	always_comb begin
		case (seg)
			rrls_pkg::SEG_R2Y: pixel = '{blue: 8'd0, green: up,    red: top};
			rrls_pkg::SEG_Y2G: pixel = '{blue: 8'd0, green: top,   red: down};
			rrls_pkg::SEG_G2C: pixel = '{blue: up,   green: top,   red: 8'd0};
			rrls_pkg::SEG_C2B: pixel = '{blue: top,  green: down,  red: 8'd0};
			rrls_pkg::SEG_B2M: pixel = '{blue: top,  green: 8'd0,  red: up};
			default:           pixel = '{blue: down, green: 8'd0,  red: top};
		endcase
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotating_rainbow_led_strip: predicts every pixel of every frame.
// Depends on rrls_pkg and the top-level RTL only.

module tb_top;

	localparam int RAMP_DEPTH  = 10;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_LIMIT = 30;
	localparam int RANDOM_ITEMS = 175;

	localparam logic FUNC_CMD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic DIR_BACK  = 1'b0;
	localparam logic DIR_FWD   = 1'b1;

	typedef struct {
		rrls_pkg::rgb_t color;
		logic           last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] command_byte, [8] direction, [15:9] zero
	logic        s_axis_tuser = 1'b0;  // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // [7:0] red, [15:8] green, [23:16] blue
	logic        m_axis_tlast;

	rotating_rainbow_led_strip u_top (.*);

	// Predictor state.
	int                     wheel_pos;
	logic [7:0]             level;
	logic [7:0]             ramp_lut [RAMP_DEPTH];
	rrls_pkg::parser_mode_t cmd_mode;
	pixel_t                 frame_q [$];

	int src_gap_max = 0;
	int sink_stall_max = 0;
	int err_count = 0;
	int tick_count = 0;
	int cmd_count = 0;
	int pixels_checked = 0;
	int cycles = 0;
	pixel_t want;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycles, frame_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("%0t: pixel %0d: %s got %0d expected %0d", $time, pixels_checked, what,
				got, exp_val);
	endtask

	function automatic void load_level(input logic [7:0] lvl);
		level = lvl;
		for (int i = 0; i < RAMP_DEPTH; i++)
			ramp_lut[i] = (i < rrls_pkg::RAMP_LEN) ?
				8'((int'(lvl) * i + rrls_pkg::RAMP_LEN / 2) / rrls_pkg::RAMP_LEN) : 8'd0;
	endfunction

	function automatic void parse_command(input logic [7:0] cmd);
		case (cmd_mode)
			rrls_pkg::PM_IDLE: cmd_mode = (cmd == rrls_pkg::CMD_BRIGHTNESS) ?
				rrls_pkg::PM_WAIT : rrls_pkg::PM_BROKEN;
			rrls_pkg::PM_WAIT: begin
				load_level(cmd);
				cmd_mode = rrls_pkg::PM_IDLE;
			end
			default: ;
		endcase
	endfunction

	// Moves the wheel one step and queues the whole frame that follows.
	function automatic void advance_wheel(input logic dir);
		int                         phase;
		logic [rrls_pkg::SEG_W-1:0] seg;
		logic [7:0]                 up, down;
		pixel_t                     px;
		if (dir == DIR_FWD)
			wheel_pos = (wheel_pos + 1) % rrls_pkg::STRIP_LENGTH;
		else
			wheel_pos = (wheel_pos + rrls_pkg::STRIP_LENGTH - 1) % rrls_pkg::STRIP_LENGTH;
		seg = rrls_pkg::SEG_W'(wheel_pos / rrls_pkg::RAMP_LEN);
		phase = wheel_pos % rrls_pkg::RAMP_LEN;
		for (int i = 0; i < rrls_pkg::STRIP_LENGTH; i++) begin
			up = ramp_lut[(phase < RAMP_DEPTH) ? phase : 0];
			down = level - up;
			px.color = '0;
			case (seg)
				rrls_pkg::SEG_R2Y: begin px.color.red = level; px.color.green = up; end
				rrls_pkg::SEG_Y2G: begin px.color.red = down; px.color.green = level; end
				rrls_pkg::SEG_G2C: begin px.color.green = level; px.color.blue = up; end
				rrls_pkg::SEG_C2B: begin px.color.green = down; px.color.blue = level; end
				rrls_pkg::SEG_B2M: begin px.color.red = up; px.color.blue = level; end
				// Magenta, and any index past it on strips that are not a multiple of six.
				default: begin px.color.red = level; px.color.blue = down; end
			endcase
			px.last = (i == rrls_pkg::STRIP_LENGTH - 1);
			frame_q.push_back(px);
			phase++;
			if (phase == rrls_pkg::RAMP_LEN) begin
				phase = 0;
				seg++;
				if (seg == rrls_pkg::SEG_M2R + 1)
					seg = rrls_pkg::SEG_R2Y;
			end
		end
	endfunction

	function automatic int pick_idle_max();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return 14;
		endcase
	endfunction

	// Drives one item and updates the prediction once its transfer has happened.
	task automatic send_item(input logic func_bit, input logic [7:0] cmd_val, input logic dir);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func_bit;
		s_axis_tdata  <= {7'd0, dir, cmd_val};
		do @(posedge clk); while (!s_axis_tready);
		if (func_bit == FUNC_TICK) begin
			tick_count++;
			advance_wheel(dir);
		end else begin
			cmd_count++;
			parse_command(cmd_val);
		end
	endtask

	task automatic send_tick(input logic dir);
		send_item(FUNC_TICK, 8'($urandom_range(0, 255)), dir);
	endtask

	task automatic send_cmd(input logic [7:0] cmd_val);
		send_item(FUNC_CMD, cmd_val, 1'($urandom_range(0, 1)));
	endtask

	// The source goes idle first so the last item is not offered again while waiting.
	task automatic wait_frames_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0) @(posedge clk);
	endtask

	// Sink: a random stall before each pixel, tready held high while it waits.
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, sink_stall_max);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid || !arst_n);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_q.size() == 0) begin
				report_mismatch("pixel with nothing expected, tdata", m_axis_tdata, 0);
			end else begin
				want = frame_q.pop_front();
				if (m_axis_tdata[7:0] !== want.color.red)
					report_mismatch("red", m_axis_tdata[7:0], want.color.red);
				if (m_axis_tdata[15:8] !== want.color.green)
					report_mismatch("green", m_axis_tdata[15:8], want.color.green);
				if (m_axis_tdata[23:16] !== want.color.blue)
					report_mismatch("blue", m_axis_tdata[23:16], want.color.blue);
				if (m_axis_tlast !== want.last)
					report_mismatch("tlast", m_axis_tlast, want.last);
			end
			pixels_checked++;
		end
	end

	// Reset brightness, including the backward wrap from position zero.
	task automatic test_reset_ramp();
		src_gap_max = 0;
		sink_stall_max = 0;
		send_tick(DIR_BACK);
		send_tick(DIR_FWD);
		send_tick(DIR_FWD);
	endtask

	task automatic test_brightness_extremes();
		logic [7:0] levels [5] = '{8'hFF, 8'h00, 8'h01, rrls_pkg::CMD_BRIGHTNESS, 8'h7F};
		src_gap_max = 14;
		sink_stall_max = 4;
		foreach (levels[i]) begin
			send_cmd(rrls_pkg::CMD_BRIGHTNESS);
			send_cmd(levels[i]);
			send_tick((i % 2 == 0) ? DIR_FWD : DIR_BACK);
		end
	endtask

	// Mostly well-formed brightness pairs and ticks that sweep around the wheel.
	task automatic test_random_traffic();
		int   sent;
		bit   paused;
		logic heading;
		logic dir;
		sent = 0;
		paused = 0;
		heading = DIR_FWD;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 25 < 3) begin
				src_gap_max = pick_idle_max();
				sink_stall_max = pick_idle_max();
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_frames_drained();
				paused = 1;
			end
			if ($urandom_range(0, 9) < 2) begin
				send_cmd(rrls_pkg::CMD_BRIGHTNESS);
				sent++;
				// A tick between the two bytes must not disturb the pending command.
				if ($urandom_range(0, 3) == 0) begin
					send_tick(heading);
					sent++;
				end
				case ($urandom_range(0, 7))
					0: send_cmd(8'h00);
					1: send_cmd(8'hFF);
					default: send_cmd(8'($urandom_range(0, 255)));
				endcase
				sent++;
			end else begin
				if ($urandom_range(0, 23) == 0)
					heading = ~heading;
				dir = ($urandom_range(0, 5) == 0) ? ~heading : heading;
				send_tick(dir);
				sent++;
			end
		end
	endtask

	// An unknown first byte locks the parser; later brightness commands must be ignored.
	task automatic test_broken_parser();
		src_gap_max = 4;
		sink_stall_max = 14;
		send_cmd(8'h42);
		send_tick(DIR_FWD);
		send_cmd(rrls_pkg::CMD_BRIGHTNESS);
		send_cmd(8'hC3);
		send_tick(DIR_BACK);
		src_gap_max = 0;
		sink_stall_max = 0;
		send_cmd(rrls_pkg::CMD_BRIGHTNESS);
		send_cmd(8'($urandom_range(0, 255)));
		send_tick(DIR_FWD);
	endtask

	initial begin
		wheel_pos = 0;
		cmd_mode = rrls_pkg::PM_IDLE;
		load_level(8'(rrls_pkg::RESET_BRIGHTNESS));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_ramp();
		test_brightness_extremes();
		test_random_traffic();
		test_broken_parser();

		wait_frames_drained();
		// Room for a refill or a stray frame to show up after the last expected pixel.
		repeat (2 * rrls_pkg::STRIP_LENGTH + 300) @(posedge clk);
		if (frame_q.size() != 0)
			report_mismatch("pixels never delivered, count", 0, frame_q.size());

		$display("Run covered %0d frame ticks and %0d command bytes; %0d pixels compared.",
			tick_count, cmd_count, pixels_checked);
		$display("Final brightness %0d, wheel position %0d, parser %s, %0d mismatches.",
			level, wheel_pos, cmd_mode.name(), err_count);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
